// ===== hdl/assert_macros.svh =====
// Assertion helper macros for the rotation integrator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked implication check, disabled while reset is high
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication check
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== hdl/rbri_pkg.sv =====
// ----------------------------------------------------------------------------
// rbri_pkg
// Shared types and arithmetic helpers for the rotation integrator.
// ----------------------------------------------------------------------------
package rbri_pkg;

   localparam int unsigned NUM_CSR = 2;
   localparam logic CSR_TIME_STEP = 1'b0;
   localparam logic CSR_PLANAR    = 1'b1;

   typedef struct packed {
      logic signed [31:0] orient_w;
      logic signed [31:0] orient_x;
      logic signed [31:0] orient_y;
      logic signed [31:0] orient_z;
      logic signed [31:0] spin_x;
      logic signed [31:0] spin_y;
      logic signed [31:0] spin_z;
      logic signed [31:0] torque_x;
      logic signed [31:0] torque_y;
      logic signed [31:0] torque_z;
      logic        [31:0] inv_inertia;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_w;
      logic signed [31:0] new_x;
      logic signed [31:0] new_y;
      logic signed [31:0] new_z;
      logic signed [31:0] spin_out_x;
      logic signed [31:0] spin_out_y;
      logic signed [31:0] spin_out_z;
      logic signed [31:0] half_spin_x;
      logic signed [31:0] half_spin_y;
      logic signed [31:0] half_spin_z;
   } rsp_type;

   // clamp a wide signed value into 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
      logic signed [71:0] hi;
      logic signed [71:0] lo;
      hi = 72'sd2147483647;
      lo = -72'sd2147483648;
      if (v > hi) sat32 = 32'sh7fffffff;
      else if (v < lo) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
   endfunction

endpackage

// ===== hdl/rbri_dtmul.sv =====
// ----------------------------------------------------------------------------
// rbri_dtmul
// Registered floor(x*dt/2^32) for a 64-bit signed x, in two partial products.
// ----------------------------------------------------------------------------
module rbri_dtmul (
   input  logic               clock,
   input  logic signed [63:0] x,
   input  logic        [31:0] dt,
   output logic signed [63:0] y
);
   logic signed [64:0] hi_ff, hi_in;
   logic        [31:0] lo_ff, lo_in;

   // stage 1: the two 32x32 products
   assign hi_in = $signed(x[63:32]) * $signed({1'b0, dt});
   assign lo_in = 32'((64'(x[31:0]) * 64'(dt)) >> 32);

   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   // stage 2: sum
   assign y = 64'(hi_ff + $signed({33'd0, lo_ff}));
endmodule

// ===== hdl/rbri_hham.sv =====
// ----------------------------------------------------------------------------
// rbri_hham
// Registered half Hamilton product (0,v)*u/2, each partial product floored.
// ----------------------------------------------------------------------------
module rbri_hham (
   input  logic               clock,
   input  logic signed [31:0] v [3],
   input  logic signed [31:0] u [4],
   output logic signed [63:0] d [4]
);
   logic signed [63:0] p_ff [4][3];
   logic signed [63:0] p_in [4][3];

   // halved partial products, signs folded in
   always_comb begin
      p_in[0][0] = -((v[0] * u[1]) >>> 1);
      p_in[0][1] = -((v[1] * u[2]) >>> 1);
      p_in[0][2] = -((v[2] * u[3]) >>> 1);
      p_in[1][0] = (u[0] * v[0]) >>> 1;
      p_in[1][1] = (v[1] * u[3]) >>> 1;
      p_in[1][2] = -((v[2] * u[2]) >>> 1);
      p_in[2][0] = (u[0] * v[1]) >>> 1;
      p_in[2][1] = (v[2] * u[1]) >>> 1;
      p_in[2][2] = -((v[0] * u[3]) >>> 1);
      p_in[3][0] = (u[0] * v[2]) >>> 1;
      p_in[3][1] = (v[0] * u[2]) >>> 1;
      p_in[3][2] = -((v[1] * u[1]) >>> 1);
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   // three-term sums
   always_comb begin
      for (int i = 0; i < 4; i++)
         d[i] = p_ff[i][0] + p_ff[i][1] + p_ff[i][2];
   end
endmodule

// ===== hdl/rigid_body_rotation_integrator.sv =====
// ----------------------------------------------------------------------------
// rigid_body_rotation_integrator
// Midpoint quaternion and spin update for one particle per cycle.
// ----------------------------------------------------------------------------
// channel | ports                     | direction
// req     | req_start/req_busy/req    | in, accepted on start && !busy
// rsp     | rsp_strobe/rsp            | out, one cycle, no back-pressure
// csr     | csr_we/csr_index/csr_data | in, written on csr_we
// One transaction enters every cycle; busy is held low.
// The response passes through the chain of registered multiplies
// (torque, dt, hamilton, dt, hamilton, dt). Reset clears the valid
// pipeline and registers; nothing stalls.
`include "assert_macros.svh"
module rigid_body_rotation_integrator (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_start,
   output logic                    req_busy,
   input  rbri_pkg::req_type       req,
   output logic                    rsp_strobe,
   output rbri_pkg::rsp_type       rsp,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [31:0]             csr_data
);
   localparam int LAT = 11;

   logic [31:0] dt_ff;
   logic        planar_ff;
   logic [LAT-1:0] vld_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff <= '0;
         planar_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            rbri_pkg::CSR_TIME_STEP: dt_ff <= csr_data;
            rbri_pkg::CSR_PLANAR:    planar_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign req_busy = 1'b0;

   // valid pipe
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[LAT-2:0], req_start};
   end
   assign rsp_strobe = vld_ff[LAT-1];

   // quaternion and spin delay lines, tap t = value delayed through t registers
   logic signed [31:0] q_d [9][4];
   logic signed [31:0] w_d [3][3];
   always_comb begin
      q_d[0][0] = req.orient_w; q_d[0][1] = req.orient_x;
      q_d[0][2] = req.orient_y; q_d[0][3] = req.orient_z;
      w_d[0][0] = req.spin_x; w_d[0][1] = req.spin_y; w_d[0][2] = req.spin_z;
   end
   for (genvar t = 1; t <= 8; t++) begin : g_qd
      always_ff @(posedge clock) q_d[t] <= q_d[t-1];
   end
   for (genvar t = 1; t < 3; t++) begin : g_wd
      always_ff @(posedge clock) w_d[t] <= w_d[t-1];
   end

   // stage 0: torque times inverse inertia
   logic signed [63:0] p_ff [3];
   logic signed [31:0] m [3];
   always_comb begin
      m[0] = planar_ff ? 32'sd0 : req.torque_x;
      m[1] = planar_ff ? 32'sd0 : req.torque_y;
      m[2] = req.torque_z;
   end
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) p_ff[i] <= 64'(m[i] * $signed({1'b0, req.inv_inertia}));
   end

   // stages 1-2: dt scaling; stage 3 register: h and f
   logic signed [63:0] s [3];
   logic signed [31:0] h_ff [3];
   logic signed [31:0] f_ff [3];
   for (genvar i = 0; i < 3; i++) begin : g_sp
      rbri_dtmul u_dt (.clock(clock), .x(p_ff[i]), .dt(dt_ff), .y(s[i]));
   end
   logic signed [31:0] f_d [8][3];
   logic signed [31:0] h_d [8][3];
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         f_ff[i] <= rbri_pkg::sat32(72'(w_d[2][i]) + 72'(s[i] >>> 16));
         h_ff[i] <= rbri_pkg::sat32(72'(w_d[2][i]) + 72'(s[i] >>> 17));
      end
   end
   // f/h enter the delay line from the stage 3 register
   always_comb begin
      f_d[0] = f_ff;
      h_d[0] = h_ff;
   end
   for (genvar t = 1; t < 8; t++) begin : g_fh
      always_ff @(posedge clock) begin
         f_d[t] <= f_d[t-1];
         h_d[t] <= h_d[t-1];
      end
   end

   // stage 4: first hamilton
   logic signed [63:0] d1 [4];
   rbri_hham u_h1 (.clock(clock), .v(h_ff), .u(q_d[3]), .d(d1));
   // dt scale of the first hamilton result
   logic signed [63:0] e1 [4];
   logic signed [31:0] qm_ff [4];
   for (genvar i = 0; i < 4; i++) begin : g_m1
      rbri_dtmul u_dt (.clock(clock), .x(d1[i]), .dt(dt_ff), .y(e1[i]));
   end
   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++)
         qm_ff[i] <= rbri_pkg::sat32(72'(q_d[5][i]) + 72'(e1[i] >>> 17));
   end

   // second hamilton (qm register, f from tap 3 of the f/h delay)
   logic signed [63:0] d2 [4];
   rbri_hham u_h2 (.clock(clock), .v(f_d[3]), .u(qm_ff), .d(d2));
   logic signed [63:0] e2 [4];
   for (genvar i = 0; i < 4; i++) begin : g_m2
      rbri_dtmul u_dt (.clock(clock), .x(d2[i]), .dt(dt_ff), .y(e2[i]));
   end
   logic signed [31:0] qn_ff [4];
   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++)
         qn_ff[i] <= rbri_pkg::sat32(72'(q_d[8][i]) + 72'(e2[i] >>> 16));
   end

   // output: qn one register behind, spins from tap 7 of the f/h delay
   logic signed [31:0] qo_ff [4];
   always_ff @(posedge clock) begin
      qo_ff <= qn_ff;
      rsp.new_w <= qo_ff[0]; rsp.new_x <= qo_ff[1];
      rsp.new_y <= qo_ff[2]; rsp.new_z <= qo_ff[3];
      rsp.spin_out_x <= f_d[7][0]; rsp.spin_out_y <= f_d[7][1];
      rsp.spin_out_z <= f_d[7][2];
      rsp.half_spin_x <= h_d[7][0]; rsp.half_spin_y <= h_d[7][1];
      rsp.half_spin_z <= h_d[7][2];
   end

   `ASSERT_IMPL(a_never_busy, clock, reset, 1'b1, !req_busy)
   `ASSERT_NEXT(a_valid_shift, clock, reset, req_start, vld_ff[0])
   `ASSERT_NEXT(a_strobe_follows, clock, reset, vld_ff[LAT-2], rsp_strobe)
endmodule

// ===== tb/sv/rbri_checker.sv =====
// ----------------------------------------------------------------------------
// rbri_checker
// Watches the request, response and register ports of the rotation
// integrator, predicts every response from the accepted requests and the
// current register values, and compares each response field by field.
// ----------------------------------------------------------------------------
module rbri_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_start,
   input  logic              req_busy,
   input  rbri_pkg::req_type req,
   input  logic              rsp_strobe,
   input  rbri_pkg::rsp_type rsp,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [31:0]       csr_data,
   output int                pending,
   output int                errors
);
   typedef logic signed [127:0] wide_type;

   // shadow copy of the registers
   logic [31:0] step_dt;
   logic        planar;

   rbri_pkg::rsp_type integ_expected[$];

   localparam string FIELD_NAME[10] = '{"new_w", "new_x", "new_y", "new_z",
      "spin_out_x", "spin_out_y", "spin_out_z",
      "half_spin_x", "half_spin_y", "half_spin_z"};

   function automatic wide_type clamp32(input wide_type v);
      if (v > wide_type'(64'sd2147483647)) return wide_type'(64'sd2147483647);
      if (v < -wide_type'(64'sd2147483648)) return -wide_type'(64'sd2147483648);
      return v;
   endfunction

   // floor(x * dt / 2^32)
   function automatic wide_type scale_dt(input wide_type x);
      wide_type dt;
      dt = wide_type'({96'd0, step_dt});
      return (x * dt) >>> 32;
   endfunction

   // half of (0,v)*u, every partial product halved with floor first
   function automatic void half_hamilton(input wide_type v[3], input wide_type u[4],
                                         output wide_type d[4]);
      d[0] = -(((v[0] * u[1]) >>> 1) + ((v[1] * u[2]) >>> 1)
               + ((v[2] * u[3]) >>> 1));
      d[1] = ((u[0] * v[0]) >>> 1) + ((v[1] * u[3]) >>> 1) - ((v[2] * u[2]) >>> 1);
      d[2] = ((u[0] * v[1]) >>> 1) + ((v[2] * u[1]) >>> 1) - ((v[0] * u[3]) >>> 1);
      d[3] = ((u[0] * v[2]) >>> 1) + ((v[0] * u[2]) >>> 1) - ((v[1] * u[1]) >>> 1);
   endfunction

   function automatic rbri_pkg::rsp_type integrate(input rbri_pkg::req_type r);
      wide_type          q[4], qm[4], qn[4], d[4];
      wide_type          w[3], m[3], f[3], h[3];
      wide_type          inv, s;
      rbri_pkg::rsp_type o;
      q[0] = r.orient_w; q[1] = r.orient_x; q[2] = r.orient_y; q[3] = r.orient_z;
      w[0] = r.spin_x;   w[1] = r.spin_y;   w[2] = r.spin_z;
      m[0] = r.torque_x; m[1] = r.torque_y; m[2] = r.torque_z;
      inv  = wide_type'({96'd0, r.inv_inertia});
      // planar run: in-plane torque ignored
      if (planar) begin
         m[0] = 0;
         m[1] = 0;
      end
      for (int i = 0; i < 3; i++) begin
         s    = scale_dt(m[i] * inv);
         f[i] = clamp32(w[i] + (s >>> 16));
         h[i] = clamp32(w[i] + (s >>> 17));
      end
      // midpoint stage, then the full step from q
      half_hamilton(h, q, d);
      for (int i = 0; i < 4; i++) qm[i] = clamp32(q[i] + (scale_dt(d[i]) >>> 17));
      half_hamilton(f, qm, d);
      for (int i = 0; i < 4; i++) qn[i] = clamp32(q[i] + (scale_dt(d[i]) >>> 16));
      o.new_w = qn[0][31:0]; o.new_x = qn[1][31:0];
      o.new_y = qn[2][31:0]; o.new_z = qn[3][31:0];
      o.spin_out_x  = f[0][31:0]; o.spin_out_y  = f[1][31:0];
      o.spin_out_z  = f[2][31:0];
      o.half_spin_x = h[0][31:0]; o.half_spin_y = h[1][31:0];
      o.half_spin_z = h[2][31:0];
      return o;
   endfunction

   always @(posedge clock) begin
      logic [319:0] exp_bits;
      logic [319:0] act_bits;
      if (reset) begin
         step_dt = '0;
         planar  = 1'b0;
         integ_expected.delete();
         errors  = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == rbri_pkg::CSR_TIME_STEP) step_dt = csr_data;
            else if (csr_index == rbri_pkg::CSR_PLANAR) planar = csr_data[0];
         end
         if (req_start && !req_busy) integ_expected.push_back(integrate(req));
         if (rsp_strobe) begin
            if (integ_expected.size() == 0) begin
               $display("%0t: unexpected transaction, actual %h", $time, rsp);
               errors++;
            end else begin
               exp_bits = integ_expected.pop_front();
               act_bits = rsp;
               for (int i = 0; i < 10; i++) begin
                  if (exp_bits[319 - 32*i -: 32] !== act_bits[319 - 32*i -: 32]) begin
                     $display("%0t: %s expected %h actual %h", $time, FIELD_NAME[i],
                              exp_bits[319 - 32*i -: 32], act_bits[319 - 32*i -: 32]);
                     errors++;
                  end
               end
            end
         end
      end
      pending = integ_expected.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the rotation integrator through several register settings with
// directed corner transactions and random particles, under varying sender
// gaps; the checker beside the block predicts and compares the responses.
// ----------------------------------------------------------------------------
module tb_top;
   logic              clock;
   logic              reset;
   logic              req_start;
   logic              req_busy;
   rbri_pkg::req_type req;
   logic              rsp_strobe;
   rbri_pkg::rsp_type rsp;
   logic              csr_we;
   logic              csr_index;
   logic [31:0]       csr_data;
   int                pending;
   int                errors;

   rigid_body_rotation_integrator dut (.*);
   rbri_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the pipeline hangs
   initial begin
      #5000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // random signed value with a random magnitude
   function automatic logic [31:0] rand_scaled();
      return $unsigned($signed($urandom) >>> $urandom_range(31, 0));
   endfunction

   function automatic rbri_pkg::req_type rand_particle();
      rbri_pkg::req_type r;
      if ($urandom_range(3, 0) == 0) begin
         r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, $urandom};
      end else begin
         // plausible particle: unit-ish quaternion, moderate vectors
         r.orient_w = $signed($urandom) >>> 1;
         r.orient_x = $signed($urandom) >>> 1;
         r.orient_y = $signed($urandom) >>> 1;
         r.orient_z = $signed($urandom) >>> 1;
         r.spin_x = rand_scaled(); r.spin_y = rand_scaled(); r.spin_z = rand_scaled();
         r.torque_x = rand_scaled(); r.torque_y = rand_scaled();
         r.torque_z = rand_scaled();
         r.inv_inertia = $urandom >> $urandom_range(31, 0);
      end
      return r;
   endfunction

   // one transaction; each cycle in front of it is idle with gap_pct chance
   task automatic send(input rbri_pkg::req_type r, input int gap_pct);
      while ($urandom_range(99, 0) < gap_pct) begin
         req_start <= 1'b0;
         @(posedge clock);
      end
      req_start <= 1'b1;
      req       <= r;
      do @(posedge clock); while (req_busy);
   endtask

   // registers only change once the pipeline has drained
   task automatic set_regs(input logic [31:0] dt, input logic plane);
      req_start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= rbri_pkg::CSR_TIME_STEP;
      csr_data  <= dt;
      @(posedge clock);
      csr_index <= rbri_pkg::CSR_PLANAR;
      csr_data  <= {31'd0, plane};
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic directed_set();
      rbri_pkg::req_type r;
      r = '0;                          send(r, 0);
      r = {11{32'hffffffff}};          send(r, 0);
      r = {11{32'h7fffffff}};          send(r, 0);
      r = {11{32'h80000000}};          send(r, 0);
      r = {11{32'h80000000}}; r.inv_inertia = 32'hffffffff; send(r, 0);
      r = {11{32'h7fffffff}}; r.inv_inertia = 32'hffffffff; send(r, 0);
      // identity orientation with spin only
      r = '0; r.orient_w = 32'sh40000000; r.spin_z = 32'sh00010000; send(r, 0);
      r.spin_x = 32'sh7fffffff; r.spin_y = 32'sh80000000; send(r, 0);
      // zero inverse inertia: spin must pass through
      r = rand_particle(); r.inv_inertia = '0; send(r, 0);
      r.torque_x = 32'sh7fffffff; r.torque_y = 32'sh80000000; send(r, 0);
      // spin already at the rail, torque pushing further
      r = rand_particle(); r.spin_x = 32'sh7fffffff; r.torque_x = 32'sh7fffffff;
      r.spin_y = 32'sh80000000; r.torque_y = 32'sh80000000;
      r.inv_inertia = 32'hffffffff; send(r, 0);
      r.orient_w = 32'sh7fffffff; r.orient_x = 32'sh80000000; send(r, 0);
      r = '0; r.torque_z = 32'sh80000000; r.inv_inertia = 32'h00010000; send(r, 0);
      repeat (6) begin
         r = rand_particle(); send(r, 0);
      end
   endtask

   initial begin
      logic [31:0] dt_list[6];
      logic        plane_list[6];
      int          gap_list[6];
      dt_list    = '{32'd0, 32'hffffffff, 32'h0, 32'd1, 32'h01000000, 32'hffffffff};
      plane_list = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
      gap_list   = '{0, 45, 35, 0, 45, 35};
      dt_list[2] = $urandom;
      reset     <= 1'b1;
      req_start <= 1'b0;
      req       <= '0;
      csr_we    <= 1'b0;
      csr_index <= rbri_pkg::CSR_TIME_STEP;
      csr_data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int p = 0; p < 6; p++) begin
         // first phase runs on the reset values
         if (p > 0) set_regs(dt_list[p], plane_list[p]);
         if (p == 1 || p == 5) directed_set();
         repeat (300) send(rand_particle(), gap_list[p]);
      end
      req_start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/rbri_pkg.sv
hdl/rbri_dtmul.sv
hdl/rbri_hham.sv
hdl/rigid_body_rotation_integrator.sv
tb/sv/rbri_checker.sv
tb/sv/tb_top.sv
